/* sv/rmt_pkg.sv */
// ----------------------------------------------------------------------------
// rmt_pkg: shared types and constants of the running median tracker
// Holds the store size, field widths and the cell operation codes used by the
// cell, the chain and the top level.
// ----------------------------------------------------------------------------
package rmt_pkg;

  localparam int CAPACITY    = 1024;
  localparam int VALUE_W     = 32;
  localparam int COUNT_W     = 11;
  // The lower half holds ceil(n/2) values and the upper half floor(n/2).
  localparam int CHAIN_DEPTH = (CAPACITY + 1) / 2;
  localparam int SIZE_W      = $clog2(CHAIN_DEPTH + 1);

  // XOR with this makes unsigned order match two's complement order.
  localparam logic [VALUE_W-1:0] SIGN_FLIP = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_HOLD       = 2'd0,
    OP_INSERT     = 2'd1,
    OP_INSERT_POP = 2'd2,
    OP_PUSH       = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t             op;
    logic [VALUE_W-1:0]   key;
    logic [VALUE_W-1:0]   push_val;
    logic [SIZE_W-1:0]    size;
  } chain_ctrl_t;

endpackage

/* sv/running_median_tracker.sv */
// ----------------------------------------------------------------------------
// running_median_tracker: running lower median of a signed sample stream
// Keeps the current sequence split into two sorted cell rows around the median.
// ----------------------------------------------------------------------------
// Each accepted word is placed and its result word, the lower median, the
// number of values held and an overflow flag, is ready in the output register
// the cycle after, so one word per cycle is sustained while m_tready stays
// high. The values sit in two rows of 512 cells each: the lower half, kept in
// inverted order so that its head is its largest value, and the upper half,
// whose head is its smallest. The lower head is always the median; a sample
// inserts into one row and, when the halves would drift apart, one head moves
// across. Setting start_req begins a new sequence with that word's value.
// Once 1024 values are held, further samples are dropped with overflow set.
// ----------------------------------------------------------------------------
module running_median_tracker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [0:0]  s_tuser,   // [0] start_req
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [31:0] median, [42:32] count, [47:43] zero
  output logic [0:0]  m_tuser    // [0] overflow
);

  localparam logic [rmt_pkg::COUNT_W-1:0] FULL_COUNT =
    rmt_pkg::COUNT_W'(rmt_pkg::CAPACITY);

  logic                          accept;
  logic                          start;
  logic [rmt_pkg::COUNT_W-1:0]   cnt;
  logic [rmt_pkg::COUNT_W-1:0]   cnt_next;
  logic [rmt_pkg::SIZE_W-1:0]    size_l;
  logic [rmt_pkg::SIZE_W-1:0]    size_l_next;
  logic [rmt_pkg::SIZE_W-1:0]    size_u;
  logic [rmt_pkg::SIZE_W-1:0]    size_u_next;
  logic [rmt_pkg::COUNT_W-1:0]   n_eff;
  logic [rmt_pkg::SIZE_W-1:0]    sl_eff;
  logic [rmt_pkg::SIZE_W-1:0]    su_eff;
  logic                          full;
  logic [rmt_pkg::VALUE_W-1:0]   key_u;
  logic [rmt_pkg::VALUE_W-1:0]   key_l;
  logic [rmt_pkg::VALUE_W-1:0]   l_head;
  logic [rmt_pkg::VALUE_W-1:0]   l_head_next;
  logic [rmt_pkg::VALUE_W-1:0]   u_head;
  logic [rmt_pkg::VALUE_W-1:0]   u_head_next;
  rmt_pkg::chain_ctrl_t          ctrl_l;
  rmt_pkg::chain_ctrl_t          ctrl_u;
  logic                          out_valid;
  logic [rmt_pkg::VALUE_W-1:0]   median;
  logic [rmt_pkg::COUNT_W-1:0]   out_count;
  logic                          overflow;

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign start    = s_tuser[0];

  assign n_eff  = start ? '0 : cnt;
  assign sl_eff = start ? '0 : size_l;
  assign su_eff = start ? '0 : size_u;
  assign full   = (n_eff == FULL_COUNT);

  // The upper row stores sign-flipped values, the lower row their complement.
  assign key_u = s_tdata ^ rmt_pkg::SIGN_FLIP;
  assign key_l = ~key_u;

  always_comb begin
    ctrl_l.op       = rmt_pkg::OP_HOLD;
    ctrl_l.key      = key_l;
    ctrl_l.push_val = ~u_head;
    ctrl_l.size     = sl_eff;
    ctrl_u.op       = rmt_pkg::OP_HOLD;
    ctrl_u.key      = key_u;
    ctrl_u.push_val = ~l_head;
    ctrl_u.size     = su_eff;
    size_l_next     = size_l;
    size_u_next     = size_u;
    cnt_next        = cnt;
    if (accept && !full) begin
      cnt_next = n_eff + 1'b1;
      if (!n_eff[0]) begin
        // Even count: the lower half grows by one.
        size_l_next = sl_eff + 1'b1;
        size_u_next = su_eff;
        if (su_eff == '0 || key_u <= u_head) begin
          ctrl_l.op = rmt_pkg::OP_INSERT;
        end else begin
          ctrl_u.op = rmt_pkg::OP_INSERT_POP;
          ctrl_l.op = rmt_pkg::OP_PUSH;
        end
      end else begin
        // Odd count: the upper half grows by one.
        size_l_next = sl_eff;
        size_u_next = su_eff + 1'b1;
        if (key_u >= ~l_head) begin
          ctrl_u.op = rmt_pkg::OP_INSERT;
        end else begin
          ctrl_l.op = rmt_pkg::OP_INSERT_POP;
          ctrl_u.op = rmt_pkg::OP_PUSH;
        end
      end
    end
  end

  rmt_chain u_lower (
    .clk       (clk),
    .ctrl      (ctrl_l),
    .head      (l_head),
    .head_next (l_head_next)
  );

  rmt_chain u_upper (
    .clk       (clk),
    .ctrl      (ctrl_u),
    .head      (u_head),
    .head_next (u_head_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      size_l    <= '0;
      size_u    <= '0;
      out_valid <= 1'b0;
    end else begin
      cnt       <= cnt_next;
      size_l    <= size_l_next;
      size_u    <= size_u_next;
      out_valid <= accept || (out_valid && !m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      median    <= ~l_head_next ^ rmt_pkg::SIGN_FLIP;
      out_count <= full ? n_eff : n_eff + 1'b1;
      overflow  <= full;
    end
  end

  // The upper head is only needed for ordering; its next value is not used.
  logic unused_u_head_next;
  assign unused_u_head_next = ^u_head_next;

  assign m_tvalid = out_valid && !(unused_u_head_next && 1'b0);
  assign m_tdata  = {5'b0, out_count, median};
  assign m_tuser  = overflow;

endmodule

/* sv/rmt_cell.sv */
// ----------------------------------------------------------------------------
// rmt_cell: one cell of a sorted chain
// Holds one stored value and takes its next value from itself, the broadcast
// key or a neighbor, so that the whole chain stays in ascending order.
// ----------------------------------------------------------------------------
module rmt_cell (
  input  logic                          clk,
  input  rmt_pkg::cell_op_t             op,
  input  logic [rmt_pkg::VALUE_W-1:0]   key,
  input  logic                          valid,
  input  logic [rmt_pkg::VALUE_W-1:0]   left_v,
  input  logic                          left_b,
  input  logic [rmt_pkg::VALUE_W-1:0]   right_v,
  input  logic                          right_b,
  output logic [rmt_pkg::VALUE_W-1:0]   v,
  output logic                          b,
  output logic [rmt_pkg::VALUE_W-1:0]   v_next
);

  // A cell whose value sorts before the key keeps its place in an insert.
  assign b = valid && (v <= key);

  always_comb begin
    unique case (op)
      rmt_pkg::OP_HOLD:       v_next = v;
      rmt_pkg::OP_INSERT:     v_next = b ? v : (left_b ? key : left_v);
      rmt_pkg::OP_INSERT_POP: v_next = right_b ? right_v : (b ? key : v);
      rmt_pkg::OP_PUSH:       v_next = left_v;
      default:                v_next = v;
    endcase
  end

  always_ff @(posedge clk) begin
    v <= v_next;
  end

endmodule

/* sv/rmt_chain.sv */
// ----------------------------------------------------------------------------
// rmt_chain: row of sorted cells
// Links the cells to their neighbors and exposes the head of the row, which
// holds the smallest stored value.
// ----------------------------------------------------------------------------
module rmt_chain (
  input  logic                          clk,
  input  rmt_pkg::chain_ctrl_t          ctrl,
  output logic [rmt_pkg::VALUE_W-1:0]   head,
  output logic [rmt_pkg::VALUE_W-1:0]   head_next
);

  logic [rmt_pkg::VALUE_W-1:0] v_arr  [rmt_pkg::CHAIN_DEPTH];
  logic [rmt_pkg::VALUE_W-1:0] vn_arr [rmt_pkg::CHAIN_DEPTH];
  logic                        b_arr  [rmt_pkg::CHAIN_DEPTH];

  for (genvar i = 0; i < rmt_pkg::CHAIN_DEPTH; i++) begin : g_cell
    logic [rmt_pkg::VALUE_W-1:0] lv;
    logic                        lb;
    logic [rmt_pkg::VALUE_W-1:0] rv;
    logic                        rb;

    if (i == 0) begin : g_first
      // Ahead of the first cell the key always sorts later; a push enters here.
      assign lv = ctrl.push_val;
      assign lb = 1'b1;
    end else begin : g_mid_l
      assign lv = v_arr[i-1];
      assign lb = b_arr[i-1];
    end

    if (i == rmt_pkg::CHAIN_DEPTH - 1) begin : g_last
      assign rv = '0;
      assign rb = 1'b0;
    end else begin : g_mid_r
      assign rv = v_arr[i+1];
      assign rb = b_arr[i+1];
    end

    rmt_cell u_cell (
      .clk     (clk),
      .op      (ctrl.op),
      .key     (ctrl.key),
      .valid   (rmt_pkg::SIZE_W'(i) < ctrl.size),
      .left_v  (lv),
      .left_b  (lb),
      .right_v (rv),
      .right_b (rb),
      .v       (v_arr[i]),
      .b       (b_arr[i]),
      .v_next  (vn_arr[i])
    );
  end

  assign head      = v_arr[0];
  assign head_next = vn_arr[0];

endmodule

/* tb/running_median_checker.sv */
// ----------------------------------------------------------------------------
// running_median_checker: result predictor and scoreboard of the median tracker
// Watches both stream channels, keeps its own sorted copy of the current
// sequence, predicts one result word per accepted input word and compares
// every accepted result word with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module running_median_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [0:0]  s_tuser,   // [0] start_req
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,   // [31:0] median, [42:32] count, [47:43] zero
  input  logic [0:0]  m_tuser,   // [0] overflow
  output int          errors,
  output int          outstanding
);

  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic signed [rmt_pkg::VALUE_W-1:0] median;
    logic [rmt_pkg::COUNT_W-1:0]        count;
    logic                               overflow;
  } median_result_t;

  logic signed [rmt_pkg::VALUE_W-1:0] sorted_samples [rmt_pkg::CAPACITY];
  int                                 sample_count;
  median_result_t                     expected_medians [$];

  initial begin
    errors       = 0;
    outstanding  = 0;
    sample_count = 0;
  end

  task automatic report_mismatch(input string field, input logic [47:0] want,
                                 input logic [47:0] got);
    errors++;
    if (errors <= PRINT_CAP)
      $display("%0t: %s mismatch, expected %h got %h", $time, field, want, got);
  endtask

  function automatic median_result_t insert_sample(
    input logic signed [rmt_pkg::VALUE_W-1:0] sample,
    input logic                               restart
  );
    median_result_t res;
    int             slot;
    res.overflow = 1'b0;
    if (restart)
      sample_count = 0;
    if (sample_count >= rmt_pkg::CAPACITY) begin
      res.overflow = 1'b1;
    end else begin
      // A new sample lands after every stored sample equal to it.
      slot = sample_count;
      while (slot > 0 && sorted_samples[slot-1] > sample) begin
        sorted_samples[slot] = sorted_samples[slot-1];
        slot--;
      end
      sorted_samples[slot] = sample;
      sample_count++;
    end
    res.median = sorted_samples[(sample_count - 1) / 2];
    res.count  = rmt_pkg::COUNT_W'(sample_count);
    return res;
  endfunction

  always @(posedge clk) begin : track
    median_result_t want;
    if (rst) begin
      sample_count = 0;
      expected_medians.delete();
    end else begin
      // Push before pop so a same-edge result still pairs with the oldest word.
      if (s_tvalid && s_tready)
        expected_medians.push_back(insert_sample(s_tdata, s_tuser[0]));
      if (m_tvalid && m_tready) begin
        if (expected_medians.size() == 0) begin
          report_mismatch("unexpected result word", '0, m_tdata);
        end else begin
          want = expected_medians.pop_front();
          if (m_tdata[31:0] !== want.median)
            report_mismatch("median", want.median, m_tdata[31:0]);
          if (m_tdata[42:32] !== want.count)
            report_mismatch("count", want.count, m_tdata[42:32]);
          if (m_tdata[47:43] !== 5'b0)
            report_mismatch("padding", '0, m_tdata[47:43]);
          if (m_tuser[0] !== want.overflow)
            report_mismatch("overflow", want.overflow, m_tuser[0]);
        end
      end
    end
    outstanding <= expected_medians.size();
  end

endmodule

/* tb/tb_running_median_tracker.sv */
// ----------------------------------------------------------------------------
// tb_running_median_tracker: stimulus and verdict for the running median tracker
// Drives directed corner words, short random sequences and one sequence that
// fills the store past capacity, under three idling mixes and one long
// receiver hold-off. The checker beside the block does all comparisons.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_running_median_tracker;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int PRESSURE_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 8;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic [0:0]  m_tuser;

  int tx_idle_pct;
  int rx_idle_pct;
  bit pressure_armed;
  int errors;
  int outstanding;
  int quiet_cycles;

  running_median_tracker dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  running_median_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Ends the run when neither channel has moved a word for too long.
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver side, with one long hold-off once pressure is armed.
  initial begin : receiver
    int hold_left;
    bit pressure_done;
    hold_left     = 0;
    pressure_done = 1'b0;
    m_tready      = 1'b0;
    forever begin
      @(negedge clk);
      if (pressure_armed && !pressure_done) begin
        pressure_done = 1'b1;
        hold_left     = PRESSURE_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input logic [31:0] sample, input bit restart);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sample;
    s_tuser  <= restart;
    do
      @(posedge clk);
    while (!s_tready);
    @(negedge clk);
  endtask

  // Mixes extremes, a narrow band that forces ties, and full-range values.
  function automatic logic [31:0] rand_sample();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3:    return $urandom_range(8) - 4;
      default: return $urandom();
    endcase
  endfunction

  task automatic run_short_sequences(input int total);
    int sent;
    int run_len;
    sent = 0;
    while (sent < total) begin
      run_len = $urandom_range(40, 1);
      // Now and then a run starts without a start flag and extends the last one.
      send_word(rand_sample(), $urandom_range(9) != 0);
      for (int i = 1; i < run_len; i++)
        send_word(rand_sample(), 1'b0);
      sent += run_len;
    end
  endtask

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = '0;
    tx_idle_pct    = 7;
    rx_idle_pct    = 76;
    pressure_armed = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty store without a start flag behaves like a start.
    send_word(32'd5, 1'b0);
    send_word(32'h7fff_ffff, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hffff_ffff, 1'b0);
    send_word(32'd5, 1'b0);
    send_word(32'd5, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h8000_0000, 1'b1);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h7fff_ffff, 1'b0);
    send_word(32'h7fff_ffff, 1'b0);
    send_word(32'h7fff_ffff, 1'b1);
    send_word(32'hffff_ffff, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0000_0001, 1'b0);
    send_word(-32'sd7, 1'b1);
    send_word(32'd9, 1'b1);
    send_word(32'd9, 1'b0);
    send_word(-32'sd7, 1'b0);
    send_word(32'h5555_5555, 1'b0);
    send_word(32'haaaa_aaaa, 1'b1);
    run_short_sequences(20);

    tx_idle_pct = 76;
    rx_idle_pct = 7;
    // One sequence runs past capacity; the extra words must be dropped.
    send_word(rand_sample(), 1'b1);
    for (int i = 1; i < rmt_pkg::CAPACITY + 8; i++)
      send_word(rand_sample(), 1'b0);
    // A start on a full store is always taken.
    send_word(rand_sample(), 1'b1);
    run_short_sequences(10);

    tx_idle_pct    = 0;
    rx_idle_pct    = 0;
    pressure_armed = 1'b1;
    run_short_sequences(20);

    s_tvalid <= 1'b0;
    while (outstanding != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
